// ----- rtl/hmns_pkg.sv -----
// ============================================================================
// hmns_pkg - shared definitions for the magnitude histogram block
// Sizes, codes, and the command/status bundles between controller and
// datapath.
// ============================================================================
package hmns_pkg;

  // Configuration of the histogram
  localparam int INPUT_LIMIT = 4096;
  localparam int MAX_SAMPLES = 1048576;
  localparam int HIST_BINS   = 4 * INPUT_LIMIT;
  localparam int BIN_AW      = $clog2(HIST_BINS);

  // Field widths
  localparam int KIND_W = 2;
  localparam int SMP_W  = 16;
  localparam int IDX_W  = 14;
  localparam int VAL_W  = 21;
  localparam int STAT_W = 2;
  localparam int MAG_W  = SMP_W + 1;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Sample counter saturates at the smaller of MAX_SAMPLES and the bin width
  localparam longint VAL_MAX_L  = (longint'(1) << VAL_W) - 1;
  localparam longint COUNT_CAP  = (longint'(MAX_SAMPLES) > VAL_MAX_L) ?
                                  VAL_MAX_L : longint'(MAX_SAMPLES);

  // Fixed point: Q1.16 normalization and one-third smoothing weight
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = VAL_W + FRAC_W + 1;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int THIRD_W   = 15;
  localparam logic [THIRD_W-1:0] THIRD_Q16 = 15'd21845;
  localparam int SUM_W     = VAL_W + 2;
  localparam int PROD_W    = SUM_W + THIRD_W;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLAMP = 2'd2;

  // Datapath selects
  typedef enum logic [1:0] {RA_MAG, RA_IDX, RA_PTR, RA_PTR1} rsel_t;
  typedef enum logic [1:0] {WD_ZERO, WD_INC, WD_QUO, WD_SMOOTH} wsel_t;
  typedef enum logic {WA_MAG, WA_PTR} wasel_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              ptr_clr;
    logic              ptr_inc;
    logic              rd_en;
    rsel_t             rsel;
    logic              we;
    wasel_t            wa;
    wsel_t             wsel;
    logic              cnt_clr;
    logic              cnt_inc;
    logic              div_start;
    logic              prev_ld;
    logic              prev_smooth;
    logic              cur_ld;
    logic              mul_ld;
    logic              emit;
    logic              emit_rd;
    logic [STAT_W-1:0] emit_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ptr_last;
    logic ptr_smooth_end;
    logic cnt_zero;
    logic cnt_full;
    logic clamp;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/hmns_div.sv -----
// ============================================================================
// hmns_div - restoring divider, one quotient bit per cycle
// Divides the rounded, scaled bin value by the sample count; the quotient
// saturates to the bin width.
// ============================================================================
module hmns_div import hmns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  logic [DVD_W-1:0]     acc_r, acc_nxt;
  logic [VAL_W-1:0]     rem_r, rem_nxt;
  logic [VAL_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [VAL_W:0]       trial;
  logic                 ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    trial   = {rem_r, acc_r[DVD_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? VAL_W'(trial - {1'b0, dsr_r}) : VAL_W'(trial);
    acc_nxt = {acc_r[DVD_W-2:0], ge};
  end

  // Control: run for DVD_W steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DVD_W - 1);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = (|acc_r[DVD_W-1:VAL_W]) ? VAL_MAX : acc_r[VAL_W-1:0];

endmodule

// ----- rtl/hmns_datapath.sv -----
// ============================================================================
// hmns_datapath - bin store, counters and arithmetic
// Holds the bin memory, sample count, sweep pointer, divider, smoothing
// multiplier and the result registers.
// ============================================================================
module hmns_datapath import hmns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [SMP_W-1:0]  in_sample,
  input  logic [IDX_W-1:0]  in_bin_index,
  output logic              out_strobe,
  output logic [VAL_W-1:0]  out_bin_value,
  output logic [STAT_W-1:0] out_status
);

  logic [VAL_W-1:0]  mem [HIST_BINS];
  logic [VAL_W-1:0]  rd_data_r;
  logic [BIN_AW-1:0] raddr, waddr;
  logic [VAL_W-1:0]  wdata;

  logic [BIN_AW-1:0] mag_r, idx_r, ptr_r;
  logic              clamp_r, idx_ok_r;
  logic [VAL_W-1:0]  cnt_r;
  logic [VAL_W-1:0]  prev_r, cur_r;
  logic [PROD_W-1:0] prod_r;

  logic [MAG_W-1:0]  mag_w;
  logic              clamp_w;
  logic [SUM_W-1:0]  sum_w;
  logic [PROD_W-1:0] rnd_w;
  logic [RND_W-1:0]  smooth_full;
  logic [VAL_W-1:0]  smooth_w;
  logic [VAL_W-1:0]  inc_w;
  logic [DVD_W-1:0]  dividend_w;
  logic [VAL_W-1:0]  quo_w;
  logic              div_done_w;

  // Magnitude of the incoming sample, clamped to the last bin
  always_comb begin
    if (in_sample[SMP_W-1]) begin
      mag_w = MAG_W'(0) - {in_sample[SMP_W-1], in_sample};
    end else begin
      mag_w = {1'b0, in_sample};
    end
    clamp_w = 32'(mag_w) > (HIST_BINS - 1);
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r    <= clamp_w ? BIN_AW'(HIST_BINS - 1) : BIN_AW'(mag_w);
      clamp_r  <= clamp_w;
      idx_r    <= BIN_AW'(in_bin_index);
      idx_ok_r <= 32'(in_bin_index) < HIST_BINS;
    end
  end

  // Sweep pointer and sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.ptr_clr)      ptr_r <= '0;
      else if (cmd.ptr_inc) ptr_r <= ptr_r + 1'b1;
      if (cmd.cnt_clr)      cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
    end
  end

  // Saturating increment and smoothing result
  always_comb begin
    inc_w       = (rd_data_r == VAL_MAX) ? rd_data_r : rd_data_r + 1'b1;
    sum_w       = SUM_W'(prev_r) + SUM_W'(cur_r) + SUM_W'(rd_data_r);
    rnd_w       = prod_r + ROUND_HALF;
    smooth_full = rnd_w[PROD_W-1:FRAC_W];
    smooth_w    = (|smooth_full[RND_W-1:VAL_W]) ? VAL_MAX : smooth_full[VAL_W-1:0];
    dividend_w  = DVD_W'({rd_data_r, FRAC_W'(0)}) + DVD_W'(cnt_r >> 1);
  end

  // Address and write data selection
  always_comb begin
    unique case (cmd.rsel)
      RA_MAG:  raddr = mag_r;
      RA_IDX:  raddr = idx_r;
      RA_PTR:  raddr = ptr_r;
      RA_PTR1: raddr = ptr_r + 1'b1;
      default: raddr = ptr_r;
    endcase
    waddr = (cmd.wa == WA_MAG) ? mag_r : ptr_r;
    unique case (cmd.wsel)
      WD_ZERO:   wdata = '0;
      WD_INC:    wdata = inc_w;
      WD_QUO:    wdata = quo_w;
      WD_SMOOTH: wdata = smooth_w;
      default:   wdata = '0;
    endcase
  end

  // Bin memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.we) mem[waddr] <= wdata;
    if (cmd.rd_en) rd_data_r <= mem[raddr];
  end

  // Smoothing window: updated left neighbor, center, product
  always_ff @(posedge clk) begin
    if (cmd.prev_ld)          prev_r <= rd_data_r;
    else if (cmd.prev_smooth) prev_r <= smooth_w;
    if (cmd.cur_ld)           cur_r  <= rd_data_r;
    if (cmd.mul_ld)           prod_r <= PROD_W'(sum_w) * PROD_W'(THIRD_Q16);
  end

  hmns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend_w),
    .divisor  (cnt_r),
    .done     (div_done_w),
    .quotient (quo_w)
  );

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bin_value <= (cmd.emit_rd && idx_ok_r) ? rd_data_r : '0;
      out_status    <= cmd.emit_status;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.ptr_last       = ptr_r == BIN_AW'(HIST_BINS - 1);
    stat.ptr_smooth_end = ptr_r == BIN_AW'(HIST_BINS - 2);
    stat.cnt_zero       = cnt_r == '0;
    stat.cnt_full       = cnt_r >= VAL_W'(COUNT_CAP);
    stat.clamp          = clamp_r;
    stat.div_done       = div_done_w;
  end

endmodule

// ----- rtl/hmns_ctrl.sv -----
// ============================================================================
// hmns_ctrl - sequencer for the histogram block
// Decodes each transaction and steps the datapath through the bin sweeps.
// ============================================================================
module hmns_ctrl import hmns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  output logic              busy,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_SMP_RD = 4'd2;
  localparam logic [3:0] S_SMP_WR = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_RD_OUT = 4'd5;
  localparam logic [3:0] S_NRM_RD = 4'd6;
  localparam logic [3:0] S_NRM_ST = 4'd7;
  localparam logic [3:0] S_NRM_DV = 4'd8;
  localparam logic [3:0] S_SM0    = 4'd9;
  localparam logic [3:0] S_SM1    = 4'd10;
  localparam logic [3:0] S_SM2    = 4'd11;
  localparam logic [3:0] S_SM_RD  = 4'd12;
  localparam logic [3:0] S_SM_MUL = 4'd13;
  localparam logic [3:0] S_SM_WR  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       clr_emit_r, clr_emit_nxt;

  // State register; reset starts the clearing sweep without a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    clr_emit_nxt = clr_emit_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_CLEAR: begin
              cmd.ptr_clr  = 1'b1;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            KIND_SAMPLE: state_nxt = S_SMP_RD;
            KIND_FINISH: begin
              if (stat.cnt_zero) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.ptr_clr = 1'b1;
                state_nxt   = S_NRM_RD;
              end
            end
            KIND_READ: state_nxt = S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // Zero every bin, one per cycle
      S_CLR: begin
        cmd.we      = 1'b1;
        cmd.wa      = WA_PTR;
        cmd.wsel    = WD_ZERO;
        cmd.cnt_clr = 1'b1;
        if (stat.ptr_last) begin
          cmd.emit     = clr_emit_r;
          clr_emit_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      // Read-modify-write of one bin
      S_SMP_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_MAG;
        state_nxt = S_SMP_WR;
      end
      S_SMP_WR: begin
        if (!stat.cnt_full) begin
          cmd.we      = 1'b1;
          cmd.wa      = WA_MAG;
          cmd.wsel    = WD_INC;
          cmd.cnt_inc = 1'b1;
        end
        cmd.emit        = 1'b1;
        cmd.emit_status = stat.clamp ? ST_CLAMP : ST_OK;
        state_nxt       = S_IDLE;
      end
      // Bin read
      S_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_IDX;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.emit    = 1'b1;
        cmd.emit_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      // Normalize sweep: read, divide, write back
      S_NRM_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_PTR;
        state_nxt = S_NRM_ST;
      end
      S_NRM_ST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_NRM_DV;
      end
      S_NRM_DV: begin
        if (stat.div_done) begin
          cmd.we   = 1'b1;
          cmd.wa   = WA_PTR;
          cmd.wsel = WD_QUO;
          if (stat.ptr_last) begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = S_SM0;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = S_NRM_RD;
          end
        end
      end
      // Smoothing: prime the window with bins 0 and 1
      S_SM0: begin
        cmd.rd_en   = 1'b1;
        cmd.rsel    = RA_PTR;
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_SM1;
      end
      S_SM1: begin
        cmd.prev_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rsel    = RA_PTR;
        state_nxt   = S_SM2;
      end
      S_SM2: begin
        cmd.cur_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rsel   = RA_PTR1;
        state_nxt  = S_SM_MUL;
      end
      S_SM_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_PTR1;
        state_nxt = S_SM_MUL;
      end
      S_SM_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_SM_WR;
      end
      // Write the smoothed bin; it becomes the left neighbor of the next
      S_SM_WR: begin
        cmd.we          = 1'b1;
        cmd.wa          = WA_PTR;
        cmd.wsel        = WD_SMOOTH;
        cmd.prev_smooth = 1'b1;
        cmd.cur_ld      = 1'b1;
        if (stat.ptr_smooth_end) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/magnitude_histogram_normalize_smooth.sv -----
// ============================================================================
// magnitude_histogram_normalize_smooth - normalized magnitude histogram
// Counts sample magnitudes into a bin store, normalizes to Q1.16 and
// applies an in-place 3-tap smoothing.
// ============================================================================
// A transaction is taken on a rising edge with start high and busy low, and
// every transaction gives exactly one result, shown for a single cycle with
// out_strobe high; the receiver cannot stall it. After reset the block runs a
// clearing pass over all HIST_BINS bins (busy high) before it takes
// anything. A sample or read transaction goes through a read state, for the
// bin memory's registered read, and a result state that, for a sample, also
// writes back; the result is on the ports once the block is idle again. A
// clear walks the bin memory at one bin per cycle, with the result in the
// cycle after the walk. A finish normalizes each bin through a
// one-bit-per-cycle divider, then smooths bins 1 to HIST_BINS-2 in place
// through a read, a multiply and a write state each; a finish with no
// samples answers in the next cycle and leaves busy low. A new transaction
// may be accepted in the cycle its predecessor's result is on the ports.
module magnitude_histogram_normalize_smooth import hmns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SMP_W-1:0]  in_sample,
  input  logic [IDX_W-1:0]  in_bin_index,
  output logic              out_strobe,
  output logic [VAL_W-1:0]  out_bin_value,
  output logic [STAT_W-1:0] out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hmns_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .busy    (busy),
    .cmd     (cmd),
    .stat    (stat)
  );

  hmns_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample     (in_sample),
    .in_bin_index  (in_bin_index),
    .out_strobe    (out_strobe),
    .out_bin_value (out_bin_value),
    .out_status    (out_status)
  );

endmodule

// ----- rtl/hmns_checker.sv -----
// ============================================================================
// hmns_checker - port-level assertions for the histogram block
// Checks reset sweep, short-transaction latency and status/value coding.
// ============================================================================
module hmns_checker import hmns_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [KIND_W-1:0] in_kind,
  input logic [SMP_W-1:0]  in_sample,
  input logic              out_strobe,
  input logic [VAL_W-1:0]  out_bin_value,
  input logic [STAT_W-1:0] out_status
);

  logic             acc;
  logic [MAG_W-1:0] mag;
  logic             over;

  assign acc  = start && !busy;
  assign mag  = in_sample[SMP_W-1] ? MAG_W'(0) - {in_sample[SMP_W-1], in_sample}
                                   : {1'b0, in_sample};
  assign over = 32'(mag) > (HIST_BINS - 1);

  // Reset always starts the clearing sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // Every accepted sample or read transaction answers with a result strobe
  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_kind == KIND_SAMPLE || in_kind == KIND_READ)) |-> ##3 out_strobe)
    else $error("missing result for sample or read");

  // An out-of-range magnitude is reported as clamped
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_kind == KIND_SAMPLE && over) |-> ##3 (out_status == ST_CLAMP))
    else $error("clamped sample not flagged");

  // A result with a status other than ok carries a zero value
  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_bin_value == '0))
    else $error("nonzero value with error status");

  // Results never carry an undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_OK || out_status == ST_EMPTY ||
                    out_status == ST_CLAMP))
    else $error("undefined status code");

endmodule

bind magnitude_histogram_normalize_smooth hmns_checker u_hmns_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_kind       (in_kind),
  .in_sample     (in_sample),
  .out_strobe    (out_strobe),
  .out_bin_value (out_bin_value),
  .out_status    (out_status)
);

// ----- tb/histogram_checker.sv -----
// ----------------------------------------------------------------------------
// histogram_checker - scoreboard for the magnitude histogram block
// Watches the command and result channels and keeps its own bin store and
// sample count. Each accepted transaction is predicted right away, and each
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module histogram_checker
  import hmns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SMP_W-1:0]  in_sample,
  input  logic [IDX_W-1:0]  in_bin_index,
  input  logic              out_strobe,
  input  logic [VAL_W-1:0]  out_bin_value,
  input  logic [STAT_W-1:0] out_status,
  output int                failure_count,
  output int                due_count,
  output int                checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } bin_result_t;

  // Shadow copy of the histogram state
  logic [VAL_W-1:0] hist_bins [HIST_BINS];
  logic [VAL_W-1:0] hist_count;

  // Results owed by the block, oldest first
  bin_result_t bin_results_due [$];

  // Apply one transaction to the shadow state and return its result
  function automatic bin_result_t predict_histogram_result(
    input logic [KIND_W-1:0] kind,
    input logic [SMP_W-1:0]  smp,
    input logic [IDX_W-1:0]  idx
  );
    bin_result_t res;
    int          mag;
    bit [63:0]   acc;
    bit [63:0]   divisor;
    res = '0;
    res.status = ST_OK;
    case (kind)
      KIND_CLEAR: begin
        for (int i = 0; i < HIST_BINS; i++) hist_bins[i] = '0;
        hist_count = '0;
      end
      KIND_SAMPLE: begin
        // magnitude of a 16-bit two's complement value, 0x8000 gives 32768
        mag = smp[SMP_W-1] ? (1 << SMP_W) - int'(smp) : int'(smp);
        if (mag > HIST_BINS - 1) begin
          mag = HIST_BINS - 1;
          res.status = ST_CLAMP;
        end
        // samples past the count cap are dropped, clamp flag still reported
        if (longint'(hist_count) < COUNT_CAP) begin
          if (hist_bins[mag] != VAL_MAX) hist_bins[mag] = hist_bins[mag] + 1'b1;
          hist_count = hist_count + 1'b1;
        end
      end
      KIND_FINISH: begin
        if (hist_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          // scale to Q1.16, round half up, saturate
          divisor = 64'(hist_count);
          for (int i = 0; i < HIST_BINS; i++) begin
            acc = ((64'(hist_bins[i]) << FRAC_W) + (divisor >> 1)) / divisor;
            hist_bins[i] = (acc > 64'(VAL_MAX)) ? VAL_MAX : acc[VAL_W-1:0];
          end
          // in-place 3-tap smoothing, end bins untouched, updates ripple up
          for (int i = 1; i < HIST_BINS - 1; i++) begin
            acc = 64'(hist_bins[i-1]) + 64'(hist_bins[i]) + 64'(hist_bins[i+1]);
            acc = (acc * 64'(THIRD_Q16) + 64'(ROUND_HALF)) >> FRAC_W;
            hist_bins[i] = (acc > 64'(VAL_MAX)) ? VAL_MAX : acc[VAL_W-1:0];
          end
        end
      end
      KIND_READ: begin
        if (int'(idx) < HIST_BINS) res.value = hist_bins[idx];
      end
    endcase
    return res;
  endfunction

  // Count a failure, show only the first few
  task automatic note_failure(input string what, input bin_result_t want);
    failure_count++;
    if (failure_count <= 10)
      $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
               $time, what, want.value, want.status, out_bin_value, out_status);
  endtask

  // Predict on accept, then compare any strobed result with the oldest entry
  always @(posedge clk) begin : watch
    bin_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < HIST_BINS; i++) hist_bins[i] = '0;
      hist_count = '0;
      bin_results_due.delete();
    end else begin
      if (start && !busy)
        bin_results_due.push_back(predict_histogram_result(in_kind, in_sample,
                                                           in_bin_index));
      if (out_strobe) begin
        if (bin_results_due.size() == 0) begin
          note_failure("result with no transaction outstanding", '0);
        end else begin
          want = bin_results_due.pop_front();
          checked_count++;
          if (want.value !== out_bin_value || want.status !== out_status)
            note_failure("result mismatch", want);
        end
      end
    end
    due_count = bin_results_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for magnitude_histogram_normalize_smooth
// Drives a directed opening (field extremes, clamping, empty and real
// finish, reads before and after normalization), then random phases of
// samples and reads in bursts with idle gaps. One phase ends in a second
// normalization over random data. Checking lives in histogram_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hmns_pkg::*;

  // the two normalizing passes dominate the run
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int RANDOM_ITEMS = 950;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SMP_W-1:0]  in_sample = '0;
  logic [IDX_W-1:0]  in_bin_index = '0;
  logic              out_strobe;
  logic [VAL_W-1:0]  out_bin_value;
  logic [STAT_W-1:0] out_status;

  int failure_count;
  int due_count;
  int checked_count;
  int cycle_count = 0;
  int burst_left = 0;
  int kinds_sent [4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  magnitude_histogram_normalize_smooth u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_sample    (in_sample),
    .in_bin_index (in_bin_index),
    .out_strobe   (out_strobe),
    .out_bin_value(out_bin_value),
    .out_status   (out_status)
  );

  histogram_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_sample    (in_sample),
    .in_bin_index (in_bin_index),
    .out_strobe   (out_strobe),
    .out_bin_value(out_bin_value),
    .out_status   (out_status),
    .failure_count(failure_count),
    .due_count    (due_count),
    .checked_count(checked_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One transaction; called at a falling edge, returns at a falling edge.
  // Bursts of back-to-back commands are separated by random idle gaps.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [SMP_W-1:0]  smp,
                           input logic [IDX_W-1:0]  idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      start        <= 1'b0;
      in_kind      <= KIND_W'($urandom());
      in_sample    <= SMP_W'($urandom());
      in_bin_index <= IDX_W'($urandom());
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start        <= 1'b1;
    in_kind      <= kind;
    in_sample    <= smp;
    in_bin_index <= idx;
    do @(posedge clk); while (busy);
    @(negedge clk);
    kinds_sent[kind]++;
  endtask

  initial begin
    int issued;
    int phase;
    int base;
    int plen;
    int mag;
    logic [SMP_W-1:0] smp;
    logic [IDX_W-1:0] idx;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: empty finish, extremes, clamps, normalize, reads
    send_item(KIND_FINISH, 16'h0000, '0);
    send_item(KIND_SAMPLE, 16'h0000, '1);
    send_item(KIND_SAMPLE, 16'h0001, '0);
    send_item(KIND_SAMPLE, 16'hFFFF, '0);
    send_item(KIND_SAMPLE, 16'h3FFF, '0);
    send_item(KIND_SAMPLE, 16'hC001, '0);
    send_item(KIND_SAMPLE, 16'h4000, '0);
    send_item(KIND_SAMPLE, 16'h8000, '0);
    send_item(KIND_SAMPLE, 16'h7FFF, '0);
    send_item(KIND_SAMPLE, 16'h0007, '0);
    send_item(KIND_READ, 16'hFFFF, 14'd0);
    send_item(KIND_READ, 16'h0000, 14'd1);
    send_item(KIND_READ, 16'h0000, 14'h3FFF);
    send_item(KIND_READ, 16'h0000, 14'd7);
    send_item(KIND_READ, 16'h0000, 14'h1FFF);
    send_item(KIND_FINISH, 16'hFFFF, '1);
    send_item(KIND_READ, 16'h0000, 14'd0);
    send_item(KIND_READ, 16'h0000, 14'd1);
    send_item(KIND_READ, 16'h0000, 14'd8);
    send_item(KIND_READ, 16'h0000, 14'h3FFE);
    send_item(KIND_READ, 16'h0000, 14'h3FFF);
    send_item(KIND_SAMPLE, 16'hFFFF, '0);
    send_item(KIND_READ, 16'h0000, 14'd1);

    // Random phases; the first keeps adding onto the normalized bins and
    // ends with a second finish, later ones start from a clear
    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      if (phase == 0) begin
        base = 0;
      end else begin
        base = $urandom_range(0, HIST_BINS - 40);
        send_item(KIND_CLEAR, SMP_W'($urandom()), IDX_W'($urandom()));
        issued++;
        if ($urandom_range(0, 1) == 1) begin
          send_item(KIND_FINISH, SMP_W'($urandom()), IDX_W'($urandom()));
          issued++;
        end
      end
      plen = $urandom_range(40, 110);
      repeat (plen) begin
        if ($urandom_range(0, 99) < 55) begin
          // mostly magnitudes in a narrow window, some full-range values
          if ($urandom_range(0, 99) < 15) begin
            smp = SMP_W'($urandom());
          end else begin
            mag = base + $urandom_range(0, 31);
            smp = ($urandom_range(0, 1) == 1) ? SMP_W'(-mag) : SMP_W'(mag);
          end
          send_item(KIND_SAMPLE, smp, IDX_W'($urandom()));
        end else begin
          if ($urandom_range(0, 99) < 70) idx = IDX_W'(base + $urandom_range(0, 33));
          else idx = IDX_W'($urandom());
          send_item(KIND_READ, SMP_W'($urandom()), idx);
        end
        issued++;
      end
      if (phase == 0) begin
        send_item(KIND_FINISH, SMP_W'($urandom()), IDX_W'($urandom()));
        issued++;
        // walk the smoothed window and both end bins
        for (int b = 0; b < 38; b++) begin
          idx = (b < 36) ? IDX_W'(b) : IDX_W'(HIST_BINS - 38 + b);
          send_item(KIND_READ, SMP_W'($urandom()), idx);
          issued++;
        end
      end
      phase++;
    end
    start <= 1'b0;

    // Drain outstanding results, then allow stray strobes to show up
    wait (due_count == 0);
    repeat (50) @(posedge clk);

    $display("Sent %0d clears, %0d samples, %0d finishes and %0d reads over %0d phases",
             kinds_sent[KIND_CLEAR], kinds_sent[KIND_SAMPLE], kinds_sent[KIND_FINISH],
             kinds_sent[KIND_READ], phase);
    $display("Checked %0d results in %0d cycles, %0d failures",
             checked_count, cycle_count, failure_count);
    if (failure_count == 0 && due_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
